[hdl/wfts_pkg.sv]
// package for the window frame time statistics block
// widths, window length and the shared cell data type; no dependencies
package wfts_pkg;
   localparam int WindowLength = 32;
   localparam int SampleBits   = 24;
   localparam int FieldBits    = 24;
   localparam int SlotBits     = $clog2(WindowLength);
   localparam int SumBits      = SampleBits + SlotBits;
   localparam int SqBits       = 2 * SampleBits;
   localparam int SumSqBits    = SqBits + SlotBits;
   localparam int VarBits      = SumSqBits + SlotBits;
   localparam int RootBits     = (VarBits + 1) / 2;
   localparam int CountBits    = $clog2(WindowLength + 1);
   localparam int RootCntBits  = $clog2(RootBits + 1);

   typedef logic [SampleBits-1:0] sample_type;
   typedef logic [FieldBits-1:0]  field_type;

   typedef struct packed {
      field_type window_mean;
      field_type window_min;
      field_type window_max;
      field_type window_std_dev;
   } result_type;

   function automatic field_type sat_field(input logic [RootBits-1:0] v);
      logic [RootBits-1:0] lim;
      begin
         lim = RootBits'((64'd1 << FieldBits) - 64'd1);
         sat_field = (v > lim) ? lim[FieldBits-1:0] : v[FieldBits-1:0];
      end
   endfunction
endpackage

[hdl/wfts_if.sv]
// valid/ready channel interface carrying a payload of a given type
// depends on nothing
interface wfts_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/wfts_cell.sv]
// one window cell: holds one sample, rotates away from the head of the row
// depends on wfts_pkg
module wfts_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  wfts_pkg::sample_type prev,
   output wfts_pkg::sample_type value
);
   import wfts_pkg::*;
   sample_type value_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (shift) begin
         value_ff <= prev;
      end
   end
   assign value = value_ff;
endmodule

[hdl/wfts_sqrt.sv]
// restoring bit-serial integer square root, one result bit per cycle
// depends on wfts_pkg
module wfts_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wfts_pkg::VarBits-1:0]      radicand,
   output logic                              done,
   output logic [wfts_pkg::RootBits-1:0]     root
);
   import wfts_pkg::*;
   localparam int RemBits = RootBits + 2;
   logic [2*RootBits-1:0]  rad_ff;
   logic [RemBits-1:0]     rem_ff;
   logic [RootBits-1:0]    root_ff;
   logic [RootCntBits-1:0] cnt_ff;
   logic                   busy_ff, done_ff;
   logic [RemBits-1:0]     trial, rem_sh;

   always_comb begin
      rem_sh = {rem_ff[RemBits-3:0], rad_ff[2*RootBits-1 -: 2]};
      trial  = {root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= RootCntBits'(RootBits);
            rad_ff  <= (2*RootBits)'(radicand);
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff <= rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[RootBits-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[RootBits-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == RootCntBits'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
   assign done = done_ff;
   assign root = root_ff;
endmodule

[hdl/window_frame_time_statistics.sv]
// Window frame time statistics over the last 32 samples, kept in a rotating row of cells.
// Each item walks once round the row for the min/max, then the square root runs one bit
// per cycle; a new sample is accepted only after the result has been taken.
// The result waits in an output register; depends on wfts_pkg, wfts_if, wfts_cell, wfts_sqrt.
module window_frame_time_statistics (
   input  logic clock,
   input  logic reset,
   wfts_if.sink   req,
   wfts_if.source rsp
);
   import wfts_pkg::*;

   typedef enum logic [1:0] {IDLE, WALK, ROOT, SEND} state_type;
   state_type state_ff;

   sample_type             cells [WindowLength];
   logic                   shift;
   logic                   load;
   logic [CountBits-1:0]   cnt_ff;
   logic [SumBits-1:0]     sum_ff;
   logic [SumSqBits-1:0]   sumsq_ff;
   sample_type             min_ff, max_ff;
   logic [VarBits-1:0]     var_ff;
   logic                   sq_start_ff;
   logic                   sq_done;
   logic [RootBits-1:0]    sq_root;
   result_type             res_ff;
   sample_type             head, oldest;
   logic [SqBits-1:0]      old_sq_ff, new_sq_ff;

   assign oldest = cells[WindowLength-1];
   assign load   = (state_ff == IDLE) && req.valid;
   assign shift  = load || (state_ff == WALK);
   assign head   = load ? req.data : oldest;

   for (genvar i = 0; i < WindowLength; i++) begin : g_cell
      wfts_cell u_cell (
         .clock(clock), .reset(reset), .shift(shift),
         .prev(i == 0 ? head : cells[(i == 0) ? 0 : i-1]),
         .value(cells[i])
      );
   end

   wfts_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start_ff),
      .radicand(var_ff), .done(sq_done), .root(sq_root)
   );

   assign req.ready = (state_ff == IDLE);
   assign rsp.valid = (state_ff == SEND);
   assign rsp.data  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         sum_ff      <= '0;
         sumsq_ff    <= '0;
         cnt_ff      <= '0;
         sq_start_ff <= 1'b0;
      end else begin
         sq_start_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (req.valid) begin
                  old_sq_ff <= SqBits'(oldest) * SqBits'(oldest);
                  new_sq_ff <= SqBits'(req.data) * SqBits'(req.data);
                  sum_ff    <= sum_ff - SumBits'(oldest) + SumBits'(req.data);
                  min_ff    <= req.data;
                  max_ff    <= req.data;
                  cnt_ff    <= CountBits'(WindowLength - 1);
                  state_ff  <= WALK;
               end
            end
            WALK: begin
               if (cnt_ff == CountBits'(WindowLength - 1)) begin
                  sumsq_ff <= sumsq_ff - SumSqBits'(old_sq_ff) + SumSqBits'(new_sq_ff);
               end
               if (cnt_ff != CountBits'(0)) begin
                  if (oldest < min_ff) min_ff <= oldest;
                  if (oldest > max_ff) max_ff <= oldest;
                  cnt_ff <= cnt_ff - 1'b1;
               end else begin
                  var_ff <= (VarBits'(sumsq_ff) << SlotBits)
                            - VarBits'(sum_ff) * VarBits'(sum_ff);
                  sq_start_ff <= 1'b1;
                  state_ff <= ROOT;
               end
            end
            ROOT: begin
               if (sq_done) begin
                  res_ff.window_mean    <= sat_field(RootBits'(sum_ff >> SlotBits));
                  res_ff.window_min     <= sat_field(RootBits'(min_ff));
                  res_ff.window_max     <= sat_field(RootBits'(max_ff));
                  res_ff.window_std_dev <= sat_field(sq_root >> SlotBits);
                  state_ff <= SEND;
               end
            end
            SEND: begin
               if (rsp.ready) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   ap_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> !req.ready) else $error("accept while busy");
   ap_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEND) |-> (res_ff.window_min <= res_ff.window_max))
      else $error("min above max");
   ap_mean_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEND) |-> (res_ff.window_mean <= res_ff.window_max))
      else $error("mean above max");
endmodule

[tb/tb_window_frame_time_statistics.sv]
// testbench for window_frame_time_statistics: random and directed samples with
// random gaps on both channels, results checked against an in-bench predictor
// depends on wfts_pkg, wfts_if and the block itself
module tb_window_frame_time_statistics;
   import wfts_pkg::*;

   logic clock;
   logic reset;
   int   errors;

   wfts_if #(.payload_type(sample_type)) req_ch (clock);
   wfts_if #(.payload_type(result_type)) rsp_ch (clock);

   window_frame_time_statistics dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   sample_type       pending_samples[$];
   result_type       expected_stats[$];
   sample_type       history[WindowLength];
   logic [SlotBits-1:0] next_slot;

   task automatic add_pending(input sample_type s);
      pending_samples.insert(pending_samples.size(), s);
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(3);
      return $urandom_range(120, 10);
   endfunction

   function automatic logic [RootBits-1:0] int_sqrt(input logic [VarBits-1:0] n);
      logic [RootBits-1:0] root;
      logic [RootBits-1:0] t;
      begin
         root = '0;
         for (int b = RootBits - 1; b >= 0; b--) begin
            t = root | (RootBits'(1) << b);
            if ({{VarBits{1'b0}}, t} * {{VarBits{1'b0}}, t} <= {{RootBits{1'b0}}, n})
               root = t;
         end
         return root;
      end
   endfunction

   function automatic result_type window_stats(input sample_type x);
      result_type r;
      logic [SumBits-1:0]   s;
      logic [SumSqBits-1:0] q;
      logic [VarBits-1:0]   n;
      sample_type           mn;
      sample_type           mx;
      begin
         history[next_slot] = x;
         next_slot = next_slot + 1'b1;
         s = '0;
         q = '0;
         mn = history[0];
         mx = history[0];
         for (int i = 0; i < WindowLength; i++) begin
            s = s + history[i];
            q = q + SumSqBits'(SqBits'(history[i]) * SqBits'(history[i]));
            if (history[i] < mn) mn = history[i];
            if (history[i] > mx) mx = history[i];
         end
         n = VarBits'(q) * VarBits'(WindowLength) - VarBits'(s) * VarBits'(s);
         r.window_mean    = FieldBits'(s / WindowLength);
         r.window_min     = mn;
         r.window_max     = mx;
         r.window_std_dev = FieldBits'(int_sqrt(n) / WindowLength);
         return r;
      end
   endfunction

   // driver
   int req_hold;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
         req_hold     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_stats.insert(expected_stats.size(), window_stats(req_ch.data));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_hold > 0) begin
               req_hold     <= req_hold - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_ch.data  <= pending_samples.pop_front();
               req_ch.valid <= 1'b1;
               req_hold     <= gap_length();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_hold;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_stats.size() == 0) begin
               $display("%0t: unexpected transfer %h", $time, rsp_ch.data);
               errors++;
            end else begin
               result_type e;
               e = expected_stats.pop_front();
               if (e.window_mean !== rsp_ch.data.window_mean) begin
                  $display("%0t: mean expected %0d actual %0d", $time,
                           e.window_mean, rsp_ch.data.window_mean);
                  errors++;
               end
               if (e.window_min !== rsp_ch.data.window_min) begin
                  $display("%0t: min expected %0d actual %0d", $time,
                           e.window_min, rsp_ch.data.window_min);
                  errors++;
               end
               if (e.window_max !== rsp_ch.data.window_max) begin
                  $display("%0t: max expected %0d actual %0d", $time,
                           e.window_max, rsp_ch.data.window_max);
                  errors++;
               end
               if (e.window_std_dev !== rsp_ch.data.window_std_dev) begin
                  $display("%0t: std dev expected %0d actual %0d", $time,
                           e.window_std_dev, rsp_ch.data.window_std_dev);
                  errors++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold     <= rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_hold     <= ($urandom_range(3) == 0) ? gap_length() : 0;
         end
      end
   end

   function automatic sample_type random_sample();
      int r;
      r = $urandom_range(99);
      if (r < 50) return sample_type'($urandom_range(40000, 8000));
      if (r < 70) return sample_type'($urandom);
      if (r < 80) return sample_type'($urandom_range(3));
      if (r < 90) return {SampleBits{1'b1}} - sample_type'($urandom_range(3));
      return sample_type'(1) << $urandom_range(SampleBits - 1);
   endfunction

   initial begin
      errors = 0;
      next_slot = '0;
      for (int i = 0; i < WindowLength; i++) history[i] = '0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      // warm-up with extremes, then 14 maxima, then zeros
      add_pending('0);
      add_pending({SampleBits{1'b1}});
      add_pending(sample_type'(1));
      add_pending(sample_type'(24'h800000));
      add_pending(sample_type'(24'h555555));
      add_pending(sample_type'(24'haaaaaa));
      for (int i = 0; i < 14; i++) add_pending({SampleBits{1'b1}});
      for (int i = 0; i < 5; i++) add_pending('0);
      for (int i = 0; i < 1700; i++) begin
         if ($urandom_range(19) == 0) begin
            sample_type c;
            c = random_sample();
            for (int k = 0; k < WindowLength + 2; k++) add_pending(c);
            i += WindowLength + 1;
         end else begin
            add_pending(random_sample());
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_samples.size() == 0 && !req_ch.valid);
      wait (expected_stats.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_stats.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(12 * 2000000);
      $display("Verification failed");
      $finish;
   end
endmodule
